// ===== design/kest_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kest_pkg
// Shared types and constants of the key edge state tracker.
// ----------------------------------------------------------------------------
package kest_pkg;

    // request codes on the input channel
    localparam logic [2:0] REQ_DOWN  = 3'd0;
    localparam logic [2:0] REQ_UP    = 3'd1;
    localparam logic [2:0] REQ_TICK  = 3'd2;
    localparam logic [2:0] REQ_QUERY = 3'd3;
    localparam logic [2:0] REQ_CLEAR = 3'd4;

    // hid usage codes
    localparam logic [7:0] HID_A         = 8'd4;
    localparam logic [7:0] HID_Z         = 8'd29;
    localparam logic [7:0] HID_1         = 8'd30;
    localparam logic [7:0] HID_0         = 8'd39;
    localparam logic [7:0] HID_BACKSPACE = 8'd42;
    localparam logic [7:0] HID_LSHIFT    = 8'd225;
    localparam logic [7:0] HID_RSHIFT    = 8'd229;

    // ascii characters
    localparam logic [6:0] CH_UPPER_A = 7'h41;
    localparam logic [6:0] CH_LOWER_A = 7'h61;
    localparam logic [6:0] CH_ZERO    = 7'h30;
    localparam logic [6:0] CH_ONE     = 7'h31;
    localparam logic [6:0] CH_TILDE   = 7'h7e;

    // depth of the command queue between front and back
    localparam int CMD_DEPTH = 2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DOWN = 2'd1,
        PH_HELD = 2'd2,
        PH_UP   = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        OP_DOWN  = 3'd0,
        OP_UP    = 3'd1,
        OP_TICK  = 3'd2,
        OP_QUERY = 3'd3,
        OP_CLEAR = 3'd4,
        OP_NOP   = 3'd5
    } t_op;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] key_code;
    } t_in_item;

    typedef struct packed {
        logic       is_down;
        logic       is_up;
        logic       is_held;
        logic       char_valid;
        logic [6:0] char_code;
    } t_out_item;

    // classified command handed from front to back
    typedef struct packed {
        t_op        op;
        logic [7:0] key;
        logic       in_range;
        logic       is_letter;
        logic       char_valid;
        logic [6:0] char_code;
    } t_cmd;

endpackage
`default_nettype wire

// ===== design/kest_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kest_front
// Accepts requests, decodes the request code and translates key codes.
// ----------------------------------------------------------------------------
module kest_front #(
    parameter int NUM_KEYS = 256
) (
    input  kest_pkg::t_in_item i_item,
    input  logic               i_valid,
    output logic               o_ready,
    output kest_pkg::t_cmd     o_cmd,
    output logic               o_cmd_valid,
    input  logic               i_cmd_ready
);
    import kest_pkg::*;

    logic [7:0] w_key;

    assign w_key       = i_item.key_code;
    assign o_cmd_valid = i_valid;
    assign o_ready     = i_cmd_ready;

    // decode and translate
    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = OP_NOP;
        o_cmd.key      = w_key;
        o_cmd.in_range = (32'(w_key) < NUM_KEYS);
        unique case (i_item.req_type)
            REQ_DOWN: begin
                o_cmd.op = OP_DOWN;
                if (w_key >= HID_A && w_key <= HID_Z) begin
                    o_cmd.is_letter  = 1'b1;
                    o_cmd.char_valid = 1'b1;
                    o_cmd.char_code  = CH_LOWER_A + 7'(w_key - HID_A);
                end else if (w_key >= HID_1 && w_key <= HID_0) begin
                    o_cmd.char_valid = 1'b1;
                    o_cmd.char_code  = (w_key == HID_0) ? CH_ZERO
                                                        : CH_ONE + 7'(w_key - HID_1);
                end else if (w_key == HID_BACKSPACE) begin
                    o_cmd.char_valid = 1'b1;
                    o_cmd.char_code  = CH_TILDE;
                end
            end
            REQ_UP:    o_cmd.op = OP_UP;
            REQ_TICK:  o_cmd.op = OP_TICK;
            REQ_QUERY: o_cmd.op = OP_QUERY;
            REQ_CLEAR: o_cmd.op = OP_CLEAR;
            default:   o_cmd.op = OP_NOP;
        endcase
    end

endmodule
`default_nettype wire

// ===== design/kest_cmd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kest_cmd_fifo
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module kest_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  kest_pkg::t_cmd i_cmd,
    input  logic           i_valid,
    output logic           o_ready,
    output kest_pkg::t_cmd o_cmd,
    output logic           o_valid,
    input  logic           i_ready
);
    import kest_pkg::*;

    localparam int PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam logic [PW-1:0] LAST = PW'(CMD_DEPTH - 1);

    t_cmd          r_buf [CMD_DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [PW:0]   r_count, n_count;
    logic          w_push, w_pop;

    assign o_ready = (r_count != (PW+1)'(CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_buf[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // pointer and count update
    always_comb begin
        n_wp    = w_push ? ((r_wp == LAST) ? '0 : r_wp + 1'b1) : r_wp;
        n_rp    = w_pop  ? ((r_rp == LAST) ? '0 : r_rp + 1'b1) : r_rp;
        n_count = r_count + (PW+1)'(w_push) - (PW+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== design/kest_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kest_back
// Phase store, frame and clear sweeps, shift tracking and result register.
// ----------------------------------------------------------------------------
module kest_back #(
    parameter int NUM_KEYS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kest_pkg::t_cmd      i_cmd,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    output kest_pkg::t_out_item o_item,
    output logic                o_valid,
    input  logic                i_ready
);
    import kest_pkg::*;

    localparam int AW = $clog2(NUM_KEYS);
    localparam logic [AW-1:0] LAST = AW'(NUM_KEYS - 1);
    localparam bit LSH_OK = (NUM_KEYS > int'(HID_LSHIFT));
    localparam bit RSH_OK = (NUM_KEYS > int'(HID_RSHIFT));
    localparam logic [6:0] CASE_DIFF = CH_LOWER_A - CH_UPPER_A;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_QRD  = 5'b00010,
        S_TRD  = 5'b00100,
        S_TWR  = 5'b01000,
        S_CLR  = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_ptr, n_ptr;
    t_phase        r_lsh, n_lsh;
    t_phase        r_rsh, n_rsh;
    t_out_item     r_out, n_out;
    logic          r_out_valid, n_out_valid;

    t_phase        r_mem [NUM_KEYS];
    t_phase        r_rd_data;
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr, w_idx;
    t_phase        w_wdata;
    logic          w_slot, w_pop, w_shift;

    function automatic t_phase tick_phase(input t_phase p);
        unique case (p)
            PH_DOWN: tick_phase = PH_HELD;
            PH_UP:   tick_phase = PH_IDLE;
            default: tick_phase = p;
        endcase
    endfunction

    function automatic logic pressed(input t_phase p);
        pressed = (p == PH_DOWN) || (p == PH_HELD);
    endfunction

    assign w_slot      = !r_out_valid || i_ready;
    assign o_cmd_ready = (r_state == S_IDLE) && w_slot;
    assign w_pop       = o_cmd_ready && i_cmd_valid;
    assign w_idx       = AW'(i_cmd.key);
    assign w_shift     = (LSH_OK && pressed(r_lsh)) || (RSH_OK && pressed(r_rsh));
    assign o_item      = r_out;
    assign o_valid     = r_out_valid;

    // command execution and sweep sequencing
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_lsh       = r_lsh;
        n_rsh       = r_rsh;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        w_we        = 1'b0;
        w_waddr     = r_ptr;
        w_wdata     = PH_IDLE;
        w_raddr     = r_ptr;
        unique case (r_state)
            S_IDLE: begin
                if (w_pop) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    unique case (i_cmd.op)
                        OP_DOWN: begin
                            n_out.char_valid = i_cmd.char_valid;
                            n_out.char_code  = (i_cmd.is_letter && w_shift)
                                             ? i_cmd.char_code - CASE_DIFF
                                             : i_cmd.char_code;
                            if (i_cmd.in_range) begin
                                w_we    = 1'b1;
                                w_waddr = w_idx;
                                w_wdata = PH_DOWN;
                                if (i_cmd.key == HID_LSHIFT) n_lsh = PH_DOWN;
                                if (i_cmd.key == HID_RSHIFT) n_rsh = PH_DOWN;
                            end
                        end
                        OP_UP: begin
                            if (i_cmd.in_range) begin
                                w_we    = 1'b1;
                                w_waddr = w_idx;
                                w_wdata = PH_UP;
                                if (i_cmd.key == HID_LSHIFT) n_lsh = PH_UP;
                                if (i_cmd.key == HID_RSHIFT) n_rsh = PH_UP;
                            end
                        end
                        OP_TICK: begin
                            n_lsh   = tick_phase(r_lsh);
                            n_rsh   = tick_phase(r_rsh);
                            n_ptr   = '0;
                            n_state = S_TRD;
                        end
                        OP_QUERY: begin
                            if (i_cmd.in_range) begin
                                n_out_valid = 1'b0;
                                w_raddr     = w_idx;
                                n_state     = S_QRD;
                            end
                        end
                        OP_CLEAR: begin
                            n_lsh   = PH_IDLE;
                            n_rsh   = PH_IDLE;
                            n_ptr   = '0;
                            n_state = S_CLR;
                        end
                        OP_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_QRD: begin
                n_out_valid   = 1'b1;
                n_out         = '0;
                n_out.is_down = (r_rd_data == PH_DOWN);
                n_out.is_up   = (r_rd_data == PH_UP);
                n_out.is_held = pressed(r_rd_data);
                n_state       = S_IDLE;
            end
            S_TRD: begin
                n_state = S_TWR;
            end
            S_TWR: begin
                w_we    = 1'b1;
                w_wdata = tick_phase(r_rd_data);
                if (r_ptr == LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr   = r_ptr + 1'b1;
                    n_state = S_TRD;
                end
            end
            S_CLR: begin
                w_we    = 1'b1;
                w_wdata = PH_IDLE;
                if (r_ptr == LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers, clearing pass starts at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_ptr       <= '0;
            r_lsh       <= PH_IDLE;
            r_rsh       <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_lsh       <= n_lsh;
            r_rsh       <= n_rsh;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // phase store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_raddr];
    end

endmodule
`default_nettype wire

// ===== design/key_edge_state_tracker_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// key_edge_state_tracker_core
// Per-key edge state tracker with direct ascii character output.
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  request   i_valid / o_ready   i_item  (req_type, key_code)
//  result    o_valid / i_ready   o_item  (is_down, is_up, is_held, char)
//
//  key down, key up, unused codes: done in the back's idle state; query: idle, then S_QRD
//  frame tick: a read-modify-write of every entry (S_TRD, then S_TWR)
//  through the phase store; clear: S_CLR writes every entry in turn
//  after reset a clearing pass over all NUM_KEYS entries runs before the first beat
//  executes, while the command queue takes up to two beats
//  one result beat per request; a stalled result holds the back, queue fills
// ----------------------------------------------------------------------------
module key_edge_state_tracker_core #(
    parameter int NUM_KEYS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  kest_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output kest_pkg::t_out_item o_item
);
    import kest_pkg::*;

    t_cmd w_fcmd, w_cmd;
    logic w_fcmd_valid, w_fcmd_ready;
    logic w_cmd_valid, w_cmd_ready;

    // front: decode and translate
    kest_front #(
        .NUM_KEYS(NUM_KEYS)
    ) u_front (
        .i_item     (i_item),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .o_cmd      (w_fcmd),
        .o_cmd_valid(w_fcmd_valid),
        .i_cmd_ready(w_fcmd_ready)
    );

    // command queue
    kest_cmd_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_fcmd),
        .i_valid(w_fcmd_valid),
        .o_ready(w_fcmd_ready),
        .o_cmd  (w_cmd),
        .o_valid(w_cmd_valid),
        .i_ready(w_cmd_ready)
    );

    // back: phase store and results
    kest_back #(
        .NUM_KEYS(NUM_KEYS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_cmd_valid(w_cmd_valid),
        .o_cmd_ready(w_cmd_ready),
        .o_item     (o_item),
        .o_valid    (o_valid),
        .i_ready    (i_ready)
    );

    // no result beat right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // requests without a key-down or query give an all-zero result next cycle
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd_valid && w_cmd_ready &&
         (w_cmd.op == OP_UP || w_cmd.op == OP_TICK ||
          w_cmd.op == OP_CLEAR || w_cmd.op == OP_NOP))
        |=> (o_valid && o_item == '0))
        else $error("non-zero or missing result for a silent request");

    // an in-range query's result follows the registered read and S_QRD, with char_valid low
    a_query_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd_valid && w_cmd_ready && w_cmd.op == OP_QUERY && w_cmd.in_range)
        |=> !o_valid ##1 (o_valid && !o_item.char_valid))
        else $error("query result out of step");

endmodule
`default_nettype wire
